FILE: rtl/triangle_block_coverage_defines.svh
// ----------------------------------------------------------------------------
// triangle_block_coverage_defines
// Assertion macros for the triangle block coverage RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BLOCK_COVERAGE_DEFINES_SVH
`define TRIANGLE_BLOCK_COVERAGE_DEFINES_SVH

// same-cycle implication
`define TBC_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Types and constants of the triangle block coverage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tbc_pkg;

	localparam int EW        = 44;
	localparam int DW        = 18;
	localparam int NE        = 3;
	localparam int PIX       = 8;
	localparam int CULL_LIM  = 15;
	localparam int LATENCY   = 6;

	typedef enum logic [1:0] {
		CLASS_OUTSIDE = 2'd0,
		CLASS_FULL    = 2'd1,
		CLASS_PARTIAL = 2'd2
	} block_class_t;

	typedef struct packed {
		logic [NE-1:0][EW-1:0] c;
		logic [NE-1:0][EW-1:0] dyx0;
		logic [NE-1:0][EW-1:0] dxy0;
		logic [NE-1:0][DW-1:0] dx;
		logic [NE-1:0][DW-1:0] dy;
		logic [EW-1:0]         a1;
		logic [EW-1:0]         a2;
	} setup_t;

	typedef struct packed {
		logic                            culled;
		logic                            outside;
		logic                            full;
		logic [NE-1:0][PIX-1:0][EW-1:0]  rb;
		logic [NE-1:0][PIX-1:0][EW-1:0]  co;
	} eval_t;

endpackage

`default_nettype wire

FILE: rtl/triangle_block_coverage.sv
// ----------------------------------------------------------------------------
// triangle_block_coverage
// Half-space coverage of one pixel block by one triangle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the three 11.16 vertices and the block position and raise start.
//   A beat is taken at every rising edge with start high and busy low; busy
//   stays low, so a new beat may enter in every cycle.
//   Each beat yields one result: done is high for exactly one cycle with
//   culled, block_class and coverage_mask valid in that cycle.
//   Throughput is one block per cycle, set by the six-stage pipeline
//   (snap, deltas, products, origin values, corners, pixel tests).
//   Results leave in the order beats entered. The receiver cannot stall;
//   it must take each result in its done cycle.
//   Reset (arst_n low) clears all stage valid bits at once; beats in flight
//   are dropped and no done is raised until new beats arrive.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_block_coverage_defines.svh"

module triangle_block_coverage #(
	parameter int BLOCK_SIZE       = 8,
	parameter int PIXEL_COORD_BITS = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [26:0] vertex_a_x,
	input  wire logic [26:0] vertex_a_y,
	input  wire logic [26:0] vertex_b_x,
	input  wire logic [26:0] vertex_b_y,
	input  wire logic [26:0] vertex_c_x,
	input  wire logic [26:0] vertex_c_y,
	input  wire logic [7:0]  block_col,
	input  wire logic [7:0]  block_row,
	output logic             done,
	output logic             culled,
	output logic [1:0]       block_class,
	output logic [63:0]      coverage_mask
);

	logic                  valid_s3, valid_s5;
	tbc_pkg::setup_t       setup_s3;
	tbc_pkg::eval_t        eval_s5;
	tbc_pkg::block_class_t class_s6;

	assign busy = 1'b0;

	tbc_setup #(
		.BLOCK_SIZE       (BLOCK_SIZE),
		.PIXEL_COORD_BITS (PIXEL_COORD_BITS)
	) u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.vertex_a_x (vertex_a_x),
		.vertex_a_y (vertex_a_y),
		.vertex_b_x (vertex_b_x),
		.vertex_b_y (vertex_b_y),
		.vertex_c_x (vertex_c_x),
		.vertex_c_y (vertex_c_y),
		.block_col  (block_col),
		.block_row  (block_row),
		.valid_s3   (valid_s3),
		.setup_s3   (setup_s3)
	);

	tbc_edge #(
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.setup_s3 (setup_s3),
		.valid_s5 (valid_s5),
		.eval_s5  (eval_s5)
	);

	tbc_classify #(
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s5  (valid_s5),
		.eval_s5   (eval_s5),
		.valid_s6  (done),
		.culled_s6 (culled),
		.class_s6  (class_s6),
		.mask_s6   (coverage_mask)
	);

	assign block_class = class_s6;

	`TBC_ASSERT_NEXT(a_latency, clk, arst_n, start && !busy, ##5 done, "result beat missing")
	`TBC_ASSERT(a_cull_class, clk, arst_n, done && culled, class_s6 == tbc_pkg::CLASS_OUTSIDE, "culled beat not outside")
	`TBC_ASSERT(a_out_mask, clk, arst_n, done && class_s6 == tbc_pkg::CLASS_OUTSIDE, coverage_mask == 64'd0, "outside beat has mask")

endmodule

`default_nettype wire

FILE: rtl/tbc_setup.sv
// ----------------------------------------------------------------------------
// tbc_setup
// Stages 1-3: snap vertices to 11.4, build edge deltas, biases and the
// edge and area products.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_setup #(
	parameter int BLOCK_SIZE       = 8,
	parameter int PIXEL_COORD_BITS = 11
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [26:0]          vertex_a_x,
	input  wire logic [26:0]          vertex_a_y,
	input  wire logic [26:0]          vertex_b_x,
	input  wire logic [26:0]          vertex_b_y,
	input  wire logic [26:0]          vertex_c_x,
	input  wire logic [26:0]          vertex_c_y,
	input  wire logic [7:0]           block_col,
	input  wire logic [7:0]           block_row,
	output logic                      valid_s3,
	output tbc_pkg::setup_t           setup_s3
);

	localparam int CW = PIXEL_COORD_BITS + 4;
	localparam int XW = 17;
	localparam int PW = tbc_pkg::DW + XW + 1;
	localparam logic [15:0] LIM = 16'((1 << CW) - 1);
	localparam logic [XW-1:0] BSTEP = XW'(BLOCK_SIZE * 16);

	logic [26:0]          vin [6];
	logic [CW-1:0]        crd_s1 [6];
	logic [XW-1:0]        x0_s1, y0_s1, x0_s2, y0_s2;
	logic                 valid_s1, valid_s2;
	logic [tbc_pkg::DW-1:0] dx_s2 [3];
	logic [tbc_pkg::DW-1:0] dy_s2 [3];
	logic [2:0]           bias_s2;
	logic [2*CW-1:0]      pc1_s2 [3];
	logic [2*CW-1:0]      pc2_s2 [3];

	assign vin[0] = vertex_a_x;
	assign vin[1] = vertex_a_y;
	assign vin[2] = vertex_b_x;
	assign vin[3] = vertex_b_y;
	assign vin[4] = vertex_c_x;
	assign vin[5] = vertex_c_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// round and clamp
	always_ff @(posedge clk) begin
		logic [27:0] sum;
		logic [15:0] r;
		for (int i = 0; i < 6; i++) begin
			sum = {1'b0, vin[i]} + 28'd2048;
			r   = sum[27:12];
			crd_s1[i] <= (r > LIM) ? LIM[CW-1:0] : r[CW-1:0];
		end
		x0_s1 <= XW'(block_col) * BSTEP + XW'(8);
		y0_s1 <= XW'(block_row) * BSTEP + XW'(8);
	end

	// deltas, bias, vertex cross products
	always_ff @(posedge clk) begin
		logic [tbc_pkg::DW-1:0] dxv, dyv;
		for (int k = 0; k < 3; k++) begin
			dxv = tbc_pkg::DW'(crd_s1[2*k]) - tbc_pkg::DW'(crd_s1[(2*k+2)%6]);
			dyv = tbc_pkg::DW'(crd_s1[2*k+1]) - tbc_pkg::DW'(crd_s1[(2*k+3)%6]);
			dx_s2[k]   <= dxv;
			dy_s2[k]   <= dyv;
			bias_s2[k] <= ($signed(dyv) > 0) || (dyv == '0 && $signed(dxv) < 0);
			pc1_s2[k]  <= crd_s1[(2*k+3)%6] * crd_s1[2*k];
			pc2_s2[k]  <= crd_s1[(2*k+2)%6] * crd_s1[2*k+1];
		end
		x0_s2 <= x0_s1;
		y0_s2 <= y0_s1;
	end

	// edge offsets and area products
	always_ff @(posedge clk) begin
		logic signed [PW-1:0] px, py, pa, pb;
		for (int k = 0; k < 3; k++) begin
			px = $signed(dy_s2[k]) * $signed({1'b0, x0_s2});
			py = $signed(dx_s2[k]) * $signed({1'b0, y0_s2});
			setup_s3.dyx0[k] <= tbc_pkg::EW'(px);
			setup_s3.dxy0[k] <= tbc_pkg::EW'(py);
			setup_s3.c[k]    <= tbc_pkg::EW'(pc1_s2[k]) - tbc_pkg::EW'(pc2_s2[k])
				+ tbc_pkg::EW'(bias_s2[k]);
			setup_s3.dx[k]   <= dx_s2[k];
			setup_s3.dy[k]   <= dy_s2[k];
		end
		pa = $signed(dx_s2[2]) * $signed(dy_s2[0]);
		pb = $signed(dx_s2[0]) * $signed(dy_s2[2]);
		setup_s3.a1 <= tbc_pkg::EW'(pa);
		setup_s3.a2 <= tbc_pkg::EW'(pb);
	end

endmodule

`default_nettype wire

FILE: rtl/tbc_edge.sv
// ----------------------------------------------------------------------------
// tbc_edge
// Stages 4-5: edge values at the block origin, cull test, corner tests,
// and row and column offsets for the pixel tests.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_edge #(
	parameter int BLOCK_SIZE = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s3,
	input  tbc_pkg::setup_t       setup_s3,
	output logic                  valid_s5,
	output tbc_pkg::eval_t        eval_s5
);

	localparam logic signed [tbc_pkg::EW-1:0] STEP = tbc_pkg::EW'(16 * BLOCK_SIZE);

	logic                           valid_s4;
	logic                           culled_s4;
	logic signed [tbc_pkg::EW-1:0]  base_s4 [3];
	logic signed [tbc_pkg::EW-1:0]  sx_s4 [3];
	logic signed [tbc_pkg::EW-1:0]  sy_s4 [3];
	logic [tbc_pkg::DW-1:0]         dx_s4 [3];
	logic [tbc_pkg::DW-1:0]         dy_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [tbc_pkg::EW-1:0] area;
		for (int k = 0; k < 3; k++) begin
			base_s4[k] <= $signed(setup_s3.c[k]) + $signed(setup_s3.dyx0[k])
				- $signed(setup_s3.dxy0[k]);
			sx_s4[k]   <= tbc_pkg::EW'($signed(setup_s3.dy[k])) * STEP;
			sy_s4[k]   <= tbc_pkg::EW'($signed(setup_s3.dx[k])) * STEP;
			dx_s4[k]   <= setup_s3.dx[k];
			dy_s4[k]   <= setup_s3.dy[k];
		end
		area = $signed(setup_s3.a1) - $signed(setup_s3.a2);
		culled_s4 <= area <= tbc_pkg::EW'(tbc_pkg::CULL_LIM);
	end

	always_ff @(posedge clk) begin
		logic signed [tbc_pkg::EW-1:0] v1, v2, v3;
		logic [3:0] pass;
		logic any_out, all_in;
		any_out = 1'b0;
		all_in  = 1'b1;
		for (int k = 0; k < 3; k++) begin
			v1 = base_s4[k] + sx_s4[k];
			v2 = base_s4[k] - sy_s4[k];
			v3 = v1 - sy_s4[k];
			pass = {v3 > 0, v2 > 0, v1 > 0, base_s4[k] > 0};
			if (pass == 4'b0000)
				any_out = 1'b1;
			if (pass != 4'b1111)
				all_in = 1'b0;
			for (int i = 0; i < tbc_pkg::PIX; i++) begin
				eval_s5.rb[k][i] <= base_s4[k]
					- tbc_pkg::EW'($signed(dx_s4[k])) * tbc_pkg::EW'(16 * i);
				eval_s5.co[k][i] <= tbc_pkg::EW'($signed(dy_s4[k])) * tbc_pkg::EW'(16 * i);
			end
		end
		eval_s5.culled  <= culled_s4;
		eval_s5.outside <= any_out;
		eval_s5.full    <= all_in;
	end

endmodule

`default_nettype wire

FILE: rtl/tbc_classify.sv
// ----------------------------------------------------------------------------
// tbc_classify
// Stage 6: per-pixel edge tests, block class and coverage mask.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_classify #(
	parameter int BLOCK_SIZE = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_s5,
	input  tbc_pkg::eval_t            eval_s5,
	output logic                      valid_s6,
	output logic                      culled_s6,
	output tbc_pkg::block_class_t     class_s6,
	output logic [63:0]               mask_s6
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s6 <= 1'b0;
		else
			valid_s6 <= valid_s5;
	end

	always_ff @(posedge clk) begin
		logic [63:0] pix, full;
		logic in_px;
		pix  = '0;
		full = '0;
		for (int iy = 0; iy < tbc_pkg::PIX; iy++) begin
			for (int ix = 0; ix < tbc_pkg::PIX; ix++) begin
				in_px = 1'b1;
				for (int k = 0; k < 3; k++) begin
					if ($signed(eval_s5.rb[k][iy]) + $signed(eval_s5.co[k][ix]) <= 0)
						in_px = 1'b0;
				end
				if (iy < BLOCK_SIZE && ix < BLOCK_SIZE) begin
					full[8*iy+ix] = 1'b1;
					pix[8*iy+ix]  = in_px;
				end
			end
		end
		culled_s6 <= eval_s5.culled;
		if (eval_s5.culled || eval_s5.outside) begin
			class_s6 <= tbc_pkg::CLASS_OUTSIDE;
			mask_s6  <= '0;
		end else if (eval_s5.full) begin
			class_s6 <= tbc_pkg::CLASS_FULL;
			mask_s6  <= full;
		end else begin
			class_s6 <= tbc_pkg::CLASS_PARTIAL;
			mask_s6  <= pix;
		end
	end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives triangles and block positions into the coverage pipeline, predicts
// cull flag, block class and pixel mask per beat, and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int BSZ = 8;
	localparam int PCB = 11;
	localparam int WD_LIMIT = 2000;

	localparam logic [26:0] Z27  = 27'd0;
	localparam logic [26:0] F27  = 27'h7FFFFFF;
	localparam logic [26:0] P2   = 27'd131072;
	localparam logic [26:0] P3   = 27'd196608;
	localparam logic [26:0] P4   = 27'd262144;
	localparam logic [26:0] P6   = 27'd393216;
	localparam logic [26:0] P8   = 27'd524288;
	localparam logic [26:0] P100 = 27'd6553600;
	localparam logic [26:0] ONE  = 27'd65536;

	typedef struct {
		logic                  culled;
		tbc_pkg::block_class_t cls;
		logic [63:0]           mask;
	} cover_t;

	typedef struct {
		longint c;
		longint dx;
		longint dy;
	} edge_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [26:0] vertex_a_x = '0, vertex_a_y = '0, vertex_b_x = '0;
	logic [26:0] vertex_b_y = '0, vertex_c_x = '0, vertex_c_y = '0;
	logic [7:0]  block_col = '0, block_row = '0;
	wire         busy, done, culled;
	wire [1:0]   block_class;
	wire [63:0]  coverage_mask;

	cover_t cover_q[$];
	int     errors = 0;
	int     idle_pct = 0;
	int     quiet = 0;

	triangle_block_coverage u_top (
		.clk, .arst_n, .start, .busy,
		.vertex_a_x, .vertex_a_y, .vertex_b_x, .vertex_b_y,
		.vertex_c_x, .vertex_c_y, .block_col, .block_row,
		.done, .culled, .block_class, .coverage_mask
	);

	always #5 clk = ~clk;

	function automatic longint snap(logic [26:0] v);
		longint r;
		r = (longint'(v) + 2048) >>> 12;
		if (r > (1 << (PCB + 4)) - 1)
			r = (1 << (PCB + 4)) - 1;
		return r;
	endfunction

	function automatic edge_t build_edge(longint xa, longint ya, longint xb, longint yb);
		edge_t e;
		e.dx = xa - xb;
		e.dy = ya - yb;
		e.c = yb * xa - xb * ya;
		if (e.dy > 0 || (e.dy == 0 && e.dx < 0))
			e.c += 1;
		return e;
	endfunction

	function automatic longint eval_edge(edge_t e, longint px, longint py);
		return e.c + e.dy * px - e.dx * py;
	endfunction

	function automatic cover_t predict_cover(logic [26:0] ax, ay, bx, by, cx, cy,
			logic [7:0] col, row);
		longint x1, y1, x2, y2, x3, y3, area, x0, y0, b;
		edge_t e[3];
		int p[3];
		cover_t r;
		x1 = snap(ax); y1 = snap(ay); x2 = snap(bx);
		y2 = snap(by); x3 = snap(cx); y3 = snap(cy);
		e[0] = build_edge(x1, y1, x2, y2);
		e[1] = build_edge(x2, y2, x3, y3);
		e[2] = build_edge(x3, y3, x1, y1);
		r.culled = 1'b0;
		r.cls = tbc_pkg::CLASS_OUTSIDE;
		r.mask = '0;
		area = (x3 - x1) * (y1 - y2) - (x1 - x2) * (y3 - y1);
		if (area <= tbc_pkg::CULL_LIM) begin
			r.culled = 1'b1;
			return r;
		end
		x0 = longint'(col) * BSZ * 16 + 8;
		y0 = longint'(row) * BSZ * 16 + 8;
		for (int k = 0; k < 3; k++) begin
			b = eval_edge(e[k], x0, y0);
			p[k] = (b > 0) + (b + e[k].dy * 16 * BSZ > 0) + (b - e[k].dx * 16 * BSZ > 0)
				+ (b + e[k].dy * 16 * BSZ - e[k].dx * 16 * BSZ > 0);
		end
		if (p[0] == 0 || p[1] == 0 || p[2] == 0)
			return r;
		if (p[0] + p[1] + p[2] == 12) begin
			r.cls = tbc_pkg::CLASS_FULL;
			r.mask = '1;
			return r;
		end
		r.cls = tbc_pkg::CLASS_PARTIAL;
		for (int iy = 0; iy < BSZ; iy++)
			for (int ix = 0; ix < BSZ; ix++)
				if (eval_edge(e[0], x0 + 16 * ix, y0 + 16 * iy) > 0 &&
						eval_edge(e[1], x0 + 16 * ix, y0 + 16 * iy) > 0 &&
						eval_edge(e[2], x0 + 16 * ix, y0 + 16 * iy) > 0)
					r.mask[8 * iy + ix] = 1'b1;
		return r;
	endfunction

	// hold start high across back-to-back beats; drop it only while idling
	task automatic send_beat(logic [26:0] ax, ay, bx, by, cx, cy, logic [7:0] col, row);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		vertex_a_x <= ax; vertex_a_y <= ay; vertex_b_x <= bx;
		vertex_b_y <= by; vertex_c_x <= cx; vertex_c_y <= cy;
		block_col <= col; block_row <= row;
		do @(posedge clk); while (busy);
		cover_q.push_back(predict_cover(ax, ay, bx, by, cx, cy, col, row));
	endtask

	task automatic drain;
		start <= 1'b0;
		while (cover_q.size() != 0)
			@(posedge clk);
		repeat (tbc_pkg::LATENCY + 2) @(posedge clk);
	endtask

	function automatic logic [26:0] near_coord(int base_px);
		int v;
		v = base_px * 65536 + $signed($urandom_range(2 * 65536 * 12)) - 65536 * 12;
		if (v < 0)
			v = 0;
		return v[26:0];
	endfunction

	task automatic send_random(int n);
		int bc, br, px, py;
		logic [26:0] ax, ay, bx, by, cx, cy;
		for (int i = 0; i < n; i++) begin
			bc = $urandom_range(20);
			br = $urandom_range(20);
			px = bc * 8 + 4;
			py = br * 8 + 4;
			case ($urandom_range(9))
				0: begin
					ax = 27'($urandom); ay = 27'($urandom); bx = 27'($urandom);
					by = 27'($urandom); cx = 27'($urandom); cy = 27'($urandom);
					bc = $urandom_range(255); br = $urandom_range(255);
				end
				1: begin
					ax = near_coord(px); ay = near_coord(py);
					bx = ax; by = ay; cx = near_coord(px); cy = near_coord(py);
				end
				default: begin
					ax = near_coord(px); ay = near_coord(py);
					bx = near_coord(px); by = near_coord(py);
					cx = near_coord(px); cy = near_coord(py);
				end
			endcase
			send_beat(ax, ay, bx, by, cx, cy, bc[7:0], br[7:0]);
		end
	endtask

	task automatic test_directed;
		send_beat(Z27, Z27, Z27, Z27, Z27, Z27, 8'd0, 8'd0);
		send_beat(F27, F27, F27, F27, F27, F27, 8'd255, 8'd255);
		send_beat(Z27, Z27, Z27, P100, P100, Z27, 8'd0, 8'd0);
		send_beat(Z27, Z27, P100, Z27, Z27, P100, 8'd0, 8'd0);
		send_beat(Z27, Z27, P100, Z27, Z27, P100, 8'd1, 8'd1);
		send_beat(Z27, Z27, P100, Z27, Z27, P100, 8'd6, 8'd6);
		send_beat(Z27, Z27, P100, Z27, Z27, P100, 8'd200, 8'd200);
		send_beat(Z27, Z27, P2, Z27, Z27, P2, 8'd0, 8'd0);
		send_beat(Z27, Z27, P8, Z27, Z27, P8, 8'd0, 8'd0);
		send_beat(27'd2047, 27'd2048, 27'd4096, 27'd6143, ONE, ONE, 8'd0, 8'd0);
		send_beat(Z27, F27, F27, F27, F27, Z27, 8'd255, 8'd255);
		send_beat(Z27, Z27, F27, Z27, Z27, F27, 8'd255, 8'd255);
		send_beat(Z27, P4, P4, P4, Z27, Z27, 8'd0, 8'd0);
		send_beat(27'h5555555, 27'h2AAAAAA, 27'h2AAAAAA, 27'h5555555, Z27, Z27,
			8'd170, 8'd85);
		send_beat(Z27, Z27, P3, P3, P6, Z27, 8'd0, 8'd0);
		drain();
	endtask

	task automatic test_random_phases;
		int pct[4] = '{0, 64, 0, 31};
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = pct[ph];
			send_random(420);
			if (ph == 1)
				drain();
		end
		idle_pct = 0;
	endtask

	always @(posedge clk) begin
		cover_t want;
		if (done) begin
			if (cover_q.size() == 0) begin
				$display("%0t: unexpected result culled=%b class=%0d mask=%h", $time,
					culled, block_class, coverage_mask);
				errors++;
			end else begin
				want = cover_q.pop_front();
				if (culled !== want.culled) begin
					$display("%0t: culled expected %b actual %b", $time, want.culled, culled);
					errors++;
				end
				if (block_class !== want.cls) begin
					$display("%0t: block_class expected %0d actual %0d", $time, want.cls,
						block_class);
					errors++;
				end
				if (coverage_mask !== want.mask) begin
					$display("%0t: coverage_mask expected %h actual %h", $time, want.mask,
						coverage_mask);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WD_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_phases();
		drain();
		if (errors == 0 && cover_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
